>>> rtl/core/tnwm_pkg.sv
// Shared types, constants and the sine table function for the node world-matrix block.
package tnwm_pkg;

  localparam int unsigned NodeBits = 6;
  localparam int unsigned AngleBits = 16;
  localparam logic signed [31:0] OneQ16 = 32'sd65536;

  // Inverse odd factorials for the sine series.
  localparam real InvF3  = 0.16666666666666666;
  localparam real InvF5  = 0.008333333333333333;
  localparam real InvF7  = 1.984126984126984e-4;
  localparam real InvF9  = 2.7557319223985893e-6;
  localparam real InvF11 = 2.505210838544172e-8;
  localparam real InvF13 = 1.6059043836821613e-10;
  localparam real InvF15 = 7.647163731819816e-13;
  localparam real InvF17 = 2.8114572543455206e-15;
  localparam real InvF19 = 8.22063524662433e-18;

  typedef struct packed {
    logic [5:0]         node_index;
    logic               has_parent;
    logic [5:0]         parent_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic [15:0]        angle;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         out_node;
    logic [1:0]         column;
    logic signed [31:0] row_zero;
    logic signed [31:0] row_one;
    logic signed [31:0] row_two;
    logic signed [31:0] row_three;
    logic               last;
  } out_item_t;

  // Classified job handed from the front end to the back end.
  typedef struct packed {
    logic [5:0]         node;
    logic               use_parent;
    logic [5:0]         parent;
    logic               store_en;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] sin_v;
    logic signed [31:0] cos_v;
  } job_t;

  // Saturate a 34-bit sum to 32 bits.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate a 50-bit sum of four shifted products to 32 bits.
  function automatic logic signed [31:0] sat50(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Sine table entry: round(sin(2*pi*i/2^bits)*65536), computed at elaboration
  // from a real-valued series; entries are constant after synthesis folding.
  function automatic logic signed [31:0] sine_entry(input int unsigned i,
                                                    input int unsigned bits);
    real th;
    real x2;
    real s;
    real x;
    int  k;
    int  q;
    int  r;
    logic signed [31:0] v;
    q = (i >> (bits - 2)) & 3;
    r = i & ((1 << (bits - 2)) - 1);
    if ((q & 1) != 0) begin
      r = (1 << (bits - 2)) - r;
    end
    // Angle within the first quarter turn: r steps of (pi/2) / 2^(bits-2).
    th = 1.5707963267948966 * r;
    for (k = 0; k < int'(bits) - 2; k++) begin
      th = th * 0.5;
    end
    x2 = th * th;
    s = th * (1.0 - x2 * (InvF3 - x2 * (InvF5 - x2 * (InvF7 - x2 * (InvF9 -
        x2 * (InvF11 - x2 * (InvF13 - x2 * (InvF15 - x2 * (InvF17 -
        x2 * InvF19)))))))));
    x = s * 65536.0;
    v = 32'($rtoi(x + 0.5));
    return ((q & 2) != 0) ? -v : v;
  endfunction

endpackage

>>> rtl/core/transform_node_world_matrix.sv
// Top level of the node world-matrix composer.
// The back end works on one item at a time with one shared multiplier; the matrix product
// runs only for an item with a parent and the store write-back only for a stored node.
// The front end and a two-entry queue can take further items meanwhile.
// Reset: synchronous active-low rst_n; then a clearing pass writes identity into the world
// store before the back end takes items.
module transform_node_world_matrix #(
  parameter int unsigned NODE_COUNT      = 64,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tnwm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tnwm_pkg::out_item_t out_data
);

  logic           f_valid;
  logic           f_ready;
  tnwm_pkg::job_t f_data;
  logic           q_valid;
  logic           q_ready;
  tnwm_pkg::job_t q_data;

  tnwm_front #(.NODE_COUNT(NODE_COUNT), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid(f_valid), .job_ready(f_ready), .job_data(f_data)
  );

  tnwm_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  tnwm_back #(.NODE_COUNT(NODE_COUNT)) u_back (
    .clk, .rst_n,
    .job_valid(q_valid), .job_ready(q_ready), .job_data(q_data),
    .out_valid, .out_ready, .out_data
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.column == 2'd3) else $error("last");
  a_col_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> ##1 out_valid &&
    out_data.column == $past(out_data.column, 2) + 2'd1) else $error("column");
`endif

endmodule

>>> rtl/core/tnwm_front.sv
// Front end: accepts items, looks up sine and cosine, classifies parent and store.
module tnwm_front #(
  parameter int unsigned NODE_COUNT      = 64,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tnwm_pkg::in_item_t in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output tnwm_pkg::job_t    job_data
);

  localparam int unsigned TabSize = 1 << SINE_TABLE_BITS;
  localparam int unsigned QuarterTab = TabSize / 4;

  logic signed [31:0] sine_tab [TabSize];
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS-1:0] cidx;
  logic                       job_valid_r;
  tnwm_pkg::job_t             job_r;

  // Constant sine table.
  for (genvar g = 0; g < TabSize; g++) begin : g_tab
    assign sine_tab[g] = tnwm_pkg::sine_entry(g, SINE_TABLE_BITS);
  end

  assign idx  = in_data.angle[15 -: SINE_TABLE_BITS];
  assign cidx = idx + SINE_TABLE_BITS'(QuarterTab);

  assign in_ready  = !job_valid_r || job_ready;
  assign job_valid = job_valid_r;
  assign job_data  = job_r;

  // Output register of the front end; holds a job until the queue takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (in_ready) begin
      job_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job_r.node       <= in_data.node_index;
      job_r.use_parent <= in_data.has_parent &&
                          (32'(in_data.parent_index) < NODE_COUNT);
      job_r.parent     <= in_data.parent_index;
      job_r.store_en   <= 32'(in_data.node_index) < NODE_COUNT;
      job_r.pos_x      <= in_data.pos_x;
      job_r.pos_y      <= in_data.pos_y;
      job_r.pos_z      <= in_data.pos_z;
      job_r.scale_x    <= in_data.scale_x;
      job_r.scale_y    <= in_data.scale_y;
      job_r.scale_z    <= in_data.scale_z;
      job_r.sin_v      <= sine_tab[idx];
      job_r.cos_v      <= sine_tab[cidx];
    end
  end

endmodule

>>> rtl/core/tnwm_queue.sv
// Two-entry queue between the front end and the back end.
module tnwm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  tnwm_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output tnwm_pkg::job_t rd_data
);

  tnwm_pkg::job_t mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) begin
        wp_r <= !wp_r;
      end
      if (do_rd) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

>>> rtl/core/tnwm_back.sv
// Back end: local matrix, times any parent world matrix; stored if the node is in range.
module tnwm_back #(
  parameter int unsigned NODE_COUNT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_ready,
  input  tnwm_pkg::job_t      job_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tnwm_pkg::out_item_t out_data
);

  localparam int unsigned NodeW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned AddrW = NodeW + 4;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StLocal = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;
  localparam logic [2:0] StWrite = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // World store: 16 entries per node, address {node, column, row}.
  logic signed [31:0] store [NODE_COUNT * 16];
  logic signed [31:0] rd_q_r;
  logic [AddrW-1:0]   rd_addr;
  logic               wr_en;
  logic [AddrW-1:0]   wr_addr;
  logic signed [31:0] wr_val;
  logic [AddrW:0]     clr_r;

  tnwm_pkg::job_t     job_r;
  logic signed [31:0] loc_r [16];
  logic signed [31:0] wm_r  [16];
  logic [4:0]         lstep_r;
  logic [6:0]         mstep_r;
  logic [3:0]         wstep_r;
  logic [1:0]         col_r;
  logic signed [49:0] acc_r;
  logic signed [63:0] prod_r;
  logic               prod_v_r;
  logic               out_valid_r;
  tnwm_pkg::out_item_t out_r;

  logic [5:0]         bstep;
  logic [5:0]         pstep;
  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic signed [63:0] asr;
  logic signed [49:0] acc_sum;

  // Multiply step decode: step = {col,row,k}; the registered store read feeds the product
  // register, which feeds the accumulator; bstep and pstep name the steps they hold.
  assign bstep   = mstep_r[5:0] - 6'd1;
  assign pstep   = mstep_r[5:0] - 6'd2;
  assign rd_addr = AddrW'({job_r.parent, mstep_r[1:0], mstep_r[3:2]});

  // One shared multiplier for local entries and the matrix product.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      StLocal: begin
        case (lstep_r[1:0])
          2'd0: begin ma = job_r.scale_x; mb = job_r.cos_v; end
          2'd1: begin ma = job_r.scale_x; mb = -job_r.sin_v; end
          2'd2: begin ma = job_r.scale_y; mb = job_r.sin_v; end
          default: begin ma = job_r.scale_y; mb = job_r.cos_v; end
        endcase
      end
      StMul: begin
        ma = rd_q_r;
        mb = loc_r[{bstep[5:4], bstep[1:0]}];
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign asr     = prod_r >>> 16;
  assign acc_sum = acc_r + 50'(asr);

  assign job_ready = state_r == StIdle;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      StClear: if (clr_r[AddrW]) state_nxt = StIdle;
      StIdle:  if (job_valid) state_nxt = StLocal;
      StLocal: begin
        if (lstep_r == 5'd4) begin
          state_nxt = job_r.use_parent ? StMul : (job_r.store_en ? StWrite : StEmit);
        end
      end
      StMul:   if (mstep_r == 7'd65) state_nxt = job_r.store_en ? StWrite : StEmit;
      StWrite: if (wstep_r == 4'd15) state_nxt = StEmit;
      StEmit:  if (out_ready && out_valid_r && col_r == 2'd3) state_nxt = StIdle;
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StClear;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == StClear) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == StEmit && !out_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Store write port: clearing pass, then the 16 entries of a node in range.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_r[AddrW-1:0];
    wr_val  = (clr_r[3:2] == clr_r[1:0]) ? tnwm_pkg::OneQ16 : '0;
    if (state_r == StClear) begin
      wr_en = !clr_r[AddrW];
    end else if (state_r == StWrite) begin
      wr_en   = 1'b1;
      wr_addr = AddrW'({job_r.node, wstep_r});
      wr_val  = wm_r[wstep_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_val;
    end
    rd_q_r <= store[rd_addr];
  end

  // Datapath sequencing.
  always_ff @(posedge clk) begin
    case (state_r)
      StIdle: begin
        job_r    <= job_data;
        lstep_r  <= '0;
        mstep_r  <= '0;
        wstep_r  <= '0;
        col_r    <= '0;
        prod_v_r <= 1'b0;
        acc_r    <= '0;
      end
      StLocal: begin
        lstep_r <= lstep_r + 5'd1;
        prod_r  <= ma * mb;
        if (lstep_r == 5'd0) begin
          loc_r[2]  <= '0;
          loc_r[3]  <= '0;
          loc_r[6]  <= '0;
          loc_r[7]  <= '0;
          loc_r[8]  <= '0;
          loc_r[9]  <= '0;
          loc_r[11] <= '0;
          loc_r[10] <= job_r.scale_z;
          loc_r[12] <= job_r.pos_x;
          loc_r[13] <= job_r.pos_y;
          loc_r[14] <= job_r.pos_z;
          loc_r[15] <= tnwm_pkg::OneQ16;
        end else begin
          case (lstep_r[1:0])
            2'd1: loc_r[0] <= tnwm_pkg::sat34(34'(asr));
            2'd2: loc_r[1] <= tnwm_pkg::sat34(34'(asr));
            2'd3: loc_r[4] <= tnwm_pkg::sat34(34'(asr));
            default: loc_r[5] <= tnwm_pkg::sat34(34'(asr));
          endcase
        end
        if (lstep_r == 5'd4) begin
          for (int i = 0; i < 16; i++) begin
            wm_r[i] <= (i == 5) ? tnwm_pkg::sat34(34'(asr)) :
                       (i == 0) ? loc_r[0] : (i == 1) ? loc_r[1] :
                       (i == 4) ? loc_r[4] : loc_r[i];
          end
        end
      end
      StMul: begin
        mstep_r  <= mstep_r + 7'd1;
        prod_v_r <= mstep_r >= 7'd1 && mstep_r <= 7'd64;
        if (mstep_r >= 7'd1) begin
          prod_r <= ma * mb;
        end
        if (prod_v_r) begin
          if (mstep_r[1:0] == 2'd2) begin
            acc_r <= 50'(asr);
          end else begin
            acc_r <= acc_sum;
          end
          if (mstep_r[1:0] == 2'd1) begin
            wm_r[pstep[5:2]] <= tnwm_pkg::sat50(acc_sum);
          end
        end
      end
      StWrite: begin
        wstep_r <= wstep_r + 4'd1;
      end
      StEmit: begin
        if (!out_valid_r) begin
          out_r.out_node  <= job_r.node;
          out_r.column    <= col_r;
          out_r.row_zero  <= wm_r[{col_r, 2'd0}];
          out_r.row_one   <= wm_r[{col_r, 2'd1}];
          out_r.row_two   <= wm_r[{col_r, 2'd2}];
          out_r.row_three <= wm_r[{col_r, 2'd3}];
          out_r.last      <= col_r == 2'd3;
        end else if (out_ready) begin
          col_r <= col_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> bench/tb_transform_node_world_matrix.sv
// Testbench for the node world-matrix composer: directed table plus random node updates.
`timescale 1ns / 1ps

module tb_transform_node_world_matrix;

  localparam int unsigned Nodes = 64;
  localparam int unsigned SinBits = 10;
  localparam int unsigned SinSize = 1 << SinBits;
  localparam int unsigned RandomItems = 380;
  localparam logic signed [31:0] MaxQ = 32'sh7fffffff;
  localparam logic signed [31:0] MinQ = 32'sh80000000;
  localparam logic signed [31:0] One = tnwm_pkg::OneQ16;

  typedef logic signed [31:0] mat_t [4][4];

  // One row of the directed table; fixed_exp marks rows with a typed-in matrix.
  typedef struct {
    tnwm_pkg::in_item_t item;
    bit                 fixed_exp;
    mat_t               mat;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  tnwm_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tnwm_pkg::out_item_t out_data;

  logic signed [31:0]  sine_lut [SinSize];
  logic signed [31:0]  world_mats [Nodes][4][4];
  tnwm_pkg::out_item_t pending_cols [$];
  stim_row_t           stim_rows [$];
  int                  fail_count = 0;
  bit                  stim_done = 1'b0;

  transform_node_world_matrix u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // Saturate a wide sum to the Q16.16 range.
  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return MaxQ;
    end else if (v < -64'sd2147483648) begin
      return MinQ;
    end
    return v[31:0];
  endfunction

  // Q16.16 product with floor shift, unsaturated.
  function automatic logic signed [63:0] fx_prod(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> 16;
  endfunction

  // Sine table over a full turn, built by quarter-wave symmetry, rounded half away from zero.
  task automatic build_sine_lut();
    int  q;
    int  r;
    real x;
    logic signed [31:0] v;
    for (int i = 0; i < SinSize; i++) begin
      q = i >> (SinBits - 2);
      r = i & ((1 << (SinBits - 2)) - 1);
      if (q[0]) begin
        r = (1 << (SinBits - 2)) - r;
      end
      x = $sin(1.5707963267948966 * r / (1 << (SinBits - 2))) * 65536.0;
      v = $rtoi(x + 0.5);
      sine_lut[i] = q[1] ? -v : v;
    end
  endtask

  task automatic clear_world_mats();
    for (int n = 0; n < Nodes; n++) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          world_mats[n][c][r] = (c == r) ? One : 32'sd0;
        end
      end
    end
  endtask

  // Compose the world matrix for one accepted transfer, update the store and
  // queue the four expected columns (typed-in matrix where the row gives one).
  task automatic compose_world(input stim_row_t row);
    logic signed [63:0] s;
    logic signed [63:0] co;
    logic signed [63:0] acc;
    logic signed [31:0] loc [4][4];
    logic signed [31:0] par [4][4];
    logic signed [31:0] wm [4][4];
    int                  idx;
    tnwm_pkg::out_item_t col;
    idx = row.item.angle >> (16 - SinBits);
    s = sine_lut[idx];
    co = sine_lut[(idx + SinSize / 4) % SinSize];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        loc[c][r] = 32'sd0;
        par[c][r] = world_mats[row.item.parent_index][c][r];
      end
    end
    loc[0][0] = clamp32(fx_prod(row.item.scale_x, co));
    loc[0][1] = clamp32(fx_prod(row.item.scale_x, -s));
    loc[1][0] = clamp32(fx_prod(row.item.scale_y, s));
    loc[1][1] = clamp32(fx_prod(row.item.scale_y, co));
    loc[2][2] = row.item.scale_z;
    loc[3][0] = row.item.pos_x;
    loc[3][1] = row.item.pos_y;
    loc[3][2] = row.item.pos_z;
    loc[3][3] = One;
    // Parent product reads the store before this node is written back.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (row.item.has_parent) begin
          acc = 0;
          for (int k = 0; k < 4; k++) begin
            acc += fx_prod(par[k][r], loc[c][k]);
          end
          wm[c][r] = clamp32(acc);
        end else begin
          wm[c][r] = loc[c][r];
        end
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        world_mats[row.item.node_index][c][r] = wm[c][r];
        if (row.fixed_exp) begin
          wm[c][r] = row.mat[c][r];
        end
      end
      col.out_node = row.item.node_index;
      col.column = c[1:0];
      col.row_zero = wm[c][0];
      col.row_one = wm[c][1];
      col.row_two = wm[c][2];
      col.row_three = wm[c][3];
      col.last = (c == 3);
      pending_cols.push_back(col);
    end
  endtask

  function automatic tnwm_pkg::in_item_t make_item(input logic [5:0] node,
                                                   input logic has_par,
                                                   input logic [5:0] par,
                                                   input logic signed [31:0] px,
                                                   input logic signed [31:0] py,
                                                   input logic signed [31:0] pz,
                                                   input logic signed [31:0] sx,
                                                   input logic signed [31:0] sy,
                                                   input logic signed [31:0] sz,
                                                   input logic [15:0] ang);
    tnwm_pkg::in_item_t it;
    it.node_index = node;
    it.has_parent = has_par;
    it.parent_index = par;
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    it.scale_x = sx;
    it.scale_y = sy;
    it.scale_z = sz;
    it.angle = ang;
    return it;
  endfunction

  task automatic add_row(input tnwm_pkg::in_item_t it, input bit fixed, input mat_t m);
    stim_row_t row;
    row.item = it;
    row.fixed_exp = fixed;
    row.mat = m;
    stim_rows.push_back(row);
  endtask

  // Directed rows: identity after reset, saturation extremes, self parent,
  // ignored parent index, quarter turns and chained parents.
  task automatic fill_directed();
    mat_t ident;
    mat_t m;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ident[c][r] = (c == r) ? One : 32'sd0;
      end
    end
    add_row(make_item(6'd0, 1'b0, 6'd0, 0, 0, 0, One, One, One, 16'h0000), 1'b1, ident);
    // Parent is the freshly reset identity of the top node.
    add_row(make_item(6'd1, 1'b1, 6'd63, 0, 0, 0, One, One, One, 16'h0000), 1'b1, ident);
    // Half turn with the most negative x scale: cos = -1 saturates the product.
    m = ident;
    m[0][0] = MaxQ;
    m[1][1] = -One;
    add_row(make_item(6'd2, 1'b0, 6'h3f, 0, 0, 0, MinQ, One, One, 16'h8000), 1'b1, m);
    // Translation and z scale at the extremes pass straight through.
    m = ident;
    m[2][2] = MinQ;
    m[3][0] = MaxQ;
    m[3][1] = MinQ;
    m[3][2] = MaxQ;
    add_row(make_item(6'd63, 1'b0, 6'd0, MaxQ, MinQ, MaxQ, One, One, MinQ, 16'h0000),
            1'b1, m);
    add_row(make_item(6'd63, 1'b1, 6'd63, 32'sh10000, -32'sh20000, 32'sh8000, MaxQ, MinQ,
                      32'sh20000, 16'h4000), 1'b0, ident);
    add_row(make_item(6'd5, 1'b1, 6'd63, MaxQ, MaxQ, MaxQ, MaxQ, MaxQ, MaxQ, 16'hffff),
            1'b0, ident);
    add_row(make_item(6'd6, 1'b1, 6'd5, MinQ, MinQ, MinQ, MinQ, MinQ, MinQ, 16'hc000),
            1'b0, ident);
    add_row(make_item(6'd7, 1'b1, 6'd6, 32'sh18000, 32'sh0, -32'sh1, 32'sh10000, 32'sh30000,
                      -32'sh10000, 16'h2000), 1'b0, ident);
    add_row(make_item(6'd7, 1'b1, 6'd7, 32'sh1, 32'sh2, 32'sh3, 32'sh8000, 32'sh8000,
                      32'sh8000, 16'h003f), 1'b0, ident);
    add_row(make_item(6'd8, 1'b0, 6'd7, 0, 0, 0, 0, 0, 0, 16'h0040), 1'b0, ident);
    add_row(make_item(6'd9, 1'b1, 6'd8, 32'sh7fff0000, 32'sh10000, 0, 32'sh10000, 32'sh10000,
                      32'sh10000, 16'h1234), 1'b0, ident);
    add_row(make_item(6'd10, 1'b1, 6'd2, 32'shfffe0000, 32'sh0, 32'sh50000, -32'sh10000,
                      32'sh20000, 32'sh10000, 16'ha5a5), 1'b0, ident);
  endtask

  // Q16.16 value: mostly modest, sometimes anything.
  function automatic logic signed [31:0] rand_q();
    if ($urandom_range(0, 5) == 0) begin
      return $urandom;
    end
    return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
  endfunction

  function automatic tnwm_pkg::in_item_t rand_item(input logic [5:0] last_node);
    tnwm_pkg::in_item_t it;
    it = make_item(6'($urandom_range(0, Nodes - 1)), $urandom_range(0, 3) != 0,
                   ($urandom_range(0, 1) != 0) ? last_node : 6'($urandom_range(0, Nodes - 1)),
                   rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                   16'($urandom));
    return it;
  endfunction

  // Drive one transfer and hold it until accepted, then predict.
  task automatic send_row(input stim_row_t row);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= row.item;
    do begin
      @(posedge clk);
    end while (!in_ready);
    compose_world(row);
    // Bursts: sometimes leave a gap of idle cycles after a transfer.
    if ($urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 20)) @(negedge clk);
    end
  endtask

  initial begin
    stim_row_t row;
    mat_t      unused;
    logic [5:0] last_node;
    build_sine_lut();
    clear_world_mats();
    fill_directed();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (stim_rows[i]) begin
      send_row(stim_rows[i]);
    end
    last_node = 6'd10;
    for (int i = 0; i < RandomItems; i++) begin
      row.item = rand_item(last_node);
      row.fixed_exp = 1'b0;
      row.mat = unused;
      last_node = row.item.node_index;
      send_row(row);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stall pattern: stretches fully ready, or ready from a random mask.
  initial begin
    logic [7:0] mask;
    int         span;
    forever begin
      mask = $urandom_range(0, 3) == 0 ? 8'hff : 8'($urandom);
      span = $urandom_range(8, 64);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        out_ready <= mask[k % 8];
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Compare each result transfer with the oldest expected column.
  always @(posedge clk) begin
    tnwm_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cols.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %h", $realtime, out_data);
        fail_count++;
      end else begin
        want = pending_cols.pop_front();
        check_field("out_node", 32'(want.out_node), 32'(out_data.out_node));
        check_field("column", 32'(want.column), 32'(out_data.column));
        check_field("row_zero", want.row_zero, out_data.row_zero);
        check_field("row_one", want.row_one, out_data.row_one);
        check_field("row_two", want.row_two, out_data.row_two);
        check_field("row_three", want.row_three, out_data.row_three);
        check_field("last", 32'(want.last), 32'(out_data.last));
      end
    end
  end

  // Drain, then let the pipeline settle before the verdict.
  initial begin
    wait (stim_done);
    while (pending_cols.size() != 0) begin
      @(posedge clk);
    end
    repeat (200) @(posedge clk);
    if (pending_cols.size() != 0) begin
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Verification failed");
    $finish;
  end

endmodule
